/* hw/rtl/mrud_pkg.sv */
// Shared types, opcode constants and register-bit helpers for the MIPS register use decoder.
package mrud_pkg;

  localparam int unsigned INSTR_W = 32;
  localparam int unsigned MASK_W  = 34;

  localparam logic [MASK_W-1:0] LO_BIT   = MASK_W'(1) << 32;
  localparam logic [MASK_W-1:0] HI_BIT   = MASK_W'(1) << 33;
  localparam logic [MASK_W-1:0] ALL_ONES = '1;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2a;
  localparam logic [5:0] OP_SW      = 6'h2b;
  localparam logic [5:0] OP_SWR     = 6'h2e;
  localparam logic [5:0] OP_LWC2    = 6'h32;
  localparam logic [5:0] OP_SWC2    = 6'h3a;

  // SPECIAL function codes.
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_BREAK   = 6'h0d;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_DIVU    = 6'h1b;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  // REGIMM rt codes.
  localparam logic [4:0] RT_BLTZ    = 5'h00;
  localparam logic [4:0] RT_BGEZ    = 5'h01;
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZAL  = 5'h11;

  // Coprocessor rs codes.
  localparam logic [4:0] RS_MF      = 5'h00;
  localparam logic [4:0] RS_CF      = 5'h02;
  localparam logic [4:0] RS_MT      = 5'h04;
  localparam logic [4:0] RS_CT      = 5'h06;
  localparam logic [4:0] RS_CO      = 5'h10;

  localparam logic [4:0] REG_RA     = 5'd31;

  typedef struct packed {
    logic [MASK_W-1:0] rd_mask;
    logic [MASK_W-1:0] wr_mask;
    logic              unknown;
  } mask_res_t;

  typedef struct packed {
    logic is_alu;
    logic rt_write;
    logic rs_read;
    logic rt_read;
  } alu_flags_t;

  // One-hot bit for a GPR read.
  function automatic logic [MASK_W-1:0] rbit(input logic [4:0] r);
    rbit = MASK_W'(1) << r;
  endfunction

  // One-hot bit for a GPR write; the zero register never shows up.
  function automatic logic [MASK_W-1:0] wbit(input logic [4:0] r);
    wbit = (MASK_W'(1) << r) & ~MASK_W'(1);
  endfunction

endpackage

/* hw/rtl/mrud_mask_dec.sv */
// Read and write register mask decode for one MIPS I instruction word.
module mrud_mask_dec (
  input  logic [mrud_pkg::INSTR_W-1:0] instr,
  output mrud_pkg::mask_res_t          res
);

  logic [5:0]                  op;
  logic [4:0]                  rs;
  logic [4:0]                  rt;
  logic [4:0]                  rd;
  logic [5:0]                  fn;
  logic [mrud_pkg::MASK_W-1:0] st;

  assign op = instr[31:26];
  assign rs = instr[25:21];
  assign rt = instr[20:16];
  assign rd = instr[15:11];
  assign fn = instr[5:0];
  assign st = mrud_pkg::rbit(rs) | mrud_pkg::rbit(rt);

  always_comb begin
    res.rd_mask = '0;
    res.wr_mask = '0;
    res.unknown = 1'b0;
    case (op)
      mrud_pkg::OP_SPECIAL: begin
        case (fn)
          mrud_pkg::FN_SLL, mrud_pkg::FN_SRL, mrud_pkg::FN_SRA: begin
            res.rd_mask = mrud_pkg::rbit(rt);
            res.wr_mask = mrud_pkg::wbit(rd);
          end
          mrud_pkg::FN_SLLV, mrud_pkg::FN_SRLV, mrud_pkg::FN_SRAV,
          mrud_pkg::FN_ADD, mrud_pkg::FN_ADDU, mrud_pkg::FN_SUB, mrud_pkg::FN_SUBU,
          mrud_pkg::FN_AND, mrud_pkg::FN_OR, mrud_pkg::FN_XOR, mrud_pkg::FN_NOR,
          mrud_pkg::FN_SLT, mrud_pkg::FN_SLTU: begin
            res.rd_mask = st;
            res.wr_mask = mrud_pkg::wbit(rd);
          end
          mrud_pkg::FN_JR: begin
            res.rd_mask = mrud_pkg::rbit(rs);
          end
          mrud_pkg::FN_JALR: begin
            res.rd_mask = mrud_pkg::rbit(rs);
            res.wr_mask = mrud_pkg::wbit(rd);
          end
          mrud_pkg::FN_SYSCALL, mrud_pkg::FN_BREAK: begin
            res.rd_mask = '0;
          end
          mrud_pkg::FN_MFHI: begin
            res.rd_mask = mrud_pkg::HI_BIT;
            res.wr_mask = mrud_pkg::wbit(rd);
          end
          mrud_pkg::FN_MTHI: begin
            res.rd_mask = mrud_pkg::rbit(rs);
            res.wr_mask = mrud_pkg::HI_BIT;
          end
          mrud_pkg::FN_MFLO: begin
            res.rd_mask = mrud_pkg::LO_BIT;
            res.wr_mask = mrud_pkg::wbit(rd);
          end
          mrud_pkg::FN_MTLO: begin
            res.rd_mask = mrud_pkg::rbit(rs);
            res.wr_mask = mrud_pkg::LO_BIT;
          end
          mrud_pkg::FN_MULT, mrud_pkg::FN_MULTU, mrud_pkg::FN_DIV, mrud_pkg::FN_DIVU: begin
            res.rd_mask = st;
            res.wr_mask = mrud_pkg::LO_BIT | mrud_pkg::HI_BIT;
          end
          default: begin
            res.unknown = 1'b1;
          end
        endcase
      end
      mrud_pkg::OP_REGIMM: begin
        if (rt == mrud_pkg::RT_BLTZ || rt == mrud_pkg::RT_BGEZ) begin
          res.rd_mask = mrud_pkg::rbit(rs);
        end else if (rt == mrud_pkg::RT_BLTZAL || rt == mrud_pkg::RT_BGEZAL) begin
          res.rd_mask = mrud_pkg::rbit(rs);
          res.wr_mask = mrud_pkg::rbit(mrud_pkg::REG_RA);
        end else begin
          res.unknown = 1'b1;
        end
      end
      mrud_pkg::OP_J: begin
        res.rd_mask = '0;
      end
      mrud_pkg::OP_JAL: begin
        res.wr_mask = mrud_pkg::rbit(mrud_pkg::REG_RA);
      end
      mrud_pkg::OP_BEQ, mrud_pkg::OP_BNE: begin
        res.rd_mask = st;
      end
      mrud_pkg::OP_BLEZ, mrud_pkg::OP_BGTZ: begin
        res.rd_mask = mrud_pkg::rbit(rs);
      end
      mrud_pkg::OP_ADDI, mrud_pkg::OP_ADDIU, mrud_pkg::OP_SLTI, mrud_pkg::OP_SLTIU,
      mrud_pkg::OP_ANDI, mrud_pkg::OP_ORI, mrud_pkg::OP_XORI: begin
        res.rd_mask = mrud_pkg::rbit(rs);
        res.wr_mask = mrud_pkg::wbit(rt);
      end
      mrud_pkg::OP_LUI: begin
        res.wr_mask = mrud_pkg::wbit(rt);
      end
      mrud_pkg::OP_COP0: begin
        // Any rs of CO is taken as a return from exception.
        if (rs == mrud_pkg::RS_MF) begin
          res.wr_mask = mrud_pkg::wbit(rt);
        end else if (rs == mrud_pkg::RS_MT) begin
          res.rd_mask = mrud_pkg::rbit(rt);
        end else if (rs == mrud_pkg::RS_CO) begin
          res.rd_mask = '0;
        end else begin
          res.unknown = 1'b1;
        end
      end
      mrud_pkg::OP_COP2: begin
        // The whole upper half of rs holds coprocessor commands.
        if (rs == mrud_pkg::RS_MF || rs == mrud_pkg::RS_CF) begin
          res.wr_mask = mrud_pkg::wbit(rt);
        end else if (rs == mrud_pkg::RS_MT || rs == mrud_pkg::RS_CT) begin
          res.rd_mask = mrud_pkg::rbit(rt);
        end else if (rs[4]) begin
          res.rd_mask = '0;
        end else begin
          res.unknown = 1'b1;
        end
      end
      mrud_pkg::OP_LB, mrud_pkg::OP_LH, mrud_pkg::OP_LW, mrud_pkg::OP_LBU,
      mrud_pkg::OP_LHU: begin
        res.rd_mask = mrud_pkg::rbit(rs);
        res.wr_mask = mrud_pkg::wbit(rt);
      end
      mrud_pkg::OP_LWL, mrud_pkg::OP_LWR: begin
        res.rd_mask = st;
        res.wr_mask = mrud_pkg::wbit(rt);
      end
      mrud_pkg::OP_SB, mrud_pkg::OP_SH, mrud_pkg::OP_SWL, mrud_pkg::OP_SW,
      mrud_pkg::OP_SWR: begin
        res.rd_mask = st;
      end
      mrud_pkg::OP_LWC2, mrud_pkg::OP_SWC2: begin
        res.rd_mask = mrud_pkg::rbit(rs);
      end
      default: begin
        res.unknown = 1'b1;
      end
    endcase
    if (res.unknown) begin
      res.rd_mask = mrud_pkg::ALL_ONES;
      res.wr_mask = mrud_pkg::ALL_ONES;
    end
  end

endmodule

/* hw/rtl/mrud_alu_class.sv */
// ALU classification flags for one MIPS I instruction word.
module mrud_alu_class (
  input  logic [mrud_pkg::INSTR_W-1:0] instr,
  output mrud_pkg::alu_flags_t         flags
);

  logic [5:0] op;
  logic [5:0] fn;

  assign op = instr[31:26];
  assign fn = instr[5:0];

  always_comb begin
    flags = '0;
    case (op)
      mrud_pkg::OP_SPECIAL: begin
        case (fn)
          mrud_pkg::FN_SLL, mrud_pkg::FN_SRL, mrud_pkg::FN_SRA: begin
            flags.is_alu  = 1'b1;
            flags.rt_read = 1'b1;
          end
          mrud_pkg::FN_SLLV, mrud_pkg::FN_SRLV, mrud_pkg::FN_SRAV,
          mrud_pkg::FN_ADD, mrud_pkg::FN_ADDU, mrud_pkg::FN_SUB, mrud_pkg::FN_SUBU,
          mrud_pkg::FN_AND, mrud_pkg::FN_OR, mrud_pkg::FN_XOR, mrud_pkg::FN_NOR,
          mrud_pkg::FN_SLT, mrud_pkg::FN_SLTU: begin
            flags.is_alu  = 1'b1;
            flags.rs_read = 1'b1;
            flags.rt_read = 1'b1;
          end
          default: begin
            flags = '0;
          end
        endcase
      end
      mrud_pkg::OP_ADDI, mrud_pkg::OP_ADDIU, mrud_pkg::OP_SLTI, mrud_pkg::OP_SLTIU,
      mrud_pkg::OP_ANDI, mrud_pkg::OP_ORI, mrud_pkg::OP_XORI: begin
        flags.is_alu   = 1'b1;
        flags.rt_write = 1'b1;
        flags.rs_read  = 1'b1;
      end
      mrud_pkg::OP_LUI: begin
        // The immediate load has no register source.
        flags.is_alu   = 1'b1;
        flags.rt_write = 1'b1;
      end
      default: begin
        flags = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/mips_register_use_decoder_unit.sv */
// Top level of the MIPS I register use decoder: input register, decode and result register.
// Pipeline: a taken request is held in the input register, decoded, and loaded into the
// result register, which shows it with out_valid high (one input register, one result
// register).
// Throughput: one request per cycle; busy is never raised and the receiver cannot stall.
// Reset: synchronous on rst_n low; it clears both valid flags, so no result is shown
// until a new request arrives. The payload registers are not reset.
module mips_register_use_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mrud_pkg::INSTR_W-1:0] in_instruction,
  output logic                         out_valid,
  output logic [mrud_pkg::MASK_W-1:0]  out_read_mask,
  output logic [mrud_pkg::MASK_W-1:0]  out_write_mask,
  output logic                         out_unknown_opcode,
  output logic                         out_is_alu,
  output logic                         out_alu_writes_rt,
  output logic                         out_alu_reads_rs,
  output logic                         out_alu_reads_rt
);

  // The decode is a single pass of shallow logic, so a request can be taken every
  // cycle; nothing ever holds the requester off.
  logic                         accept;

  // Input stage.
  logic                         in_valid_r;
  logic                         in_valid_nxt;
  logic [mrud_pkg::INSTR_W-1:0] instr_r;

  // Decode results between the stages.
  mrud_pkg::mask_res_t          mask_res;
  mrud_pkg::alu_flags_t         alu_flags;

  // Result stage.
  logic                         res_valid_r;
  logic                         res_valid_nxt;
  mrud_pkg::mask_res_t          mask_r;
  mrud_pkg::alu_flags_t         flags_r;

  assign busy          = 1'b0;
  assign accept        = start && !busy;
  assign in_valid_nxt  = accept;
  assign res_valid_nxt = in_valid_r;

  // Control flags, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // The instruction word is captured only when a request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r <= in_instruction;
    end
  end

  // Two decoders work side by side on the registered word.
  mrud_mask_dec u_mask_dec (
    .instr (instr_r),
    .res   (mask_res)
  );

  mrud_alu_class u_alu_class (
    .instr (instr_r),
    .flags (alu_flags)
  );

  // The result register is loaded whenever the input stage holds a word; it is shown
  // for exactly one cycle unless the next word follows right behind it.
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      mask_r  <= mask_res;
      flags_r <= alu_flags;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_read_mask      = mask_r.rd_mask;
  assign out_write_mask     = mask_r.wr_mask;
  assign out_unknown_opcode = mask_r.unknown;
  assign out_is_alu         = flags_r.is_alu;
  assign out_alu_writes_rt  = flags_r.rt_write;
  assign out_alu_reads_rs   = flags_r.rs_read;
  assign out_alu_reads_rt   = flags_r.rt_read;

endmodule

/* hw/rtl/mrud_checker.sv */
// Port-level assertions for the register use decoder, bound to its top level.
module mrud_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [mrud_pkg::MASK_W-1:0]  out_read_mask,
  input logic [mrud_pkg::MASK_W-1:0]  out_write_mask,
  input logic                         out_unknown_opcode,
  input logic                         out_is_alu,
  input logic                         out_alu_writes_rt,
  input logic                         out_alu_reads_rs,
  input logic                         out_alu_reads_rt
);

  // Every request gives its result once it has passed the input and result registers.
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request did not produce a result two cycles later");

  // A result never appears without a request taken through both registers before it.
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result shown without a matching request");

  // An unrecognized word reads and writes everything and is no ALU operation.
  a_unknown_barrier: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unknown_opcode) |->
      (out_read_mask == mrud_pkg::ALL_ONES && out_write_mask == mrud_pkg::ALL_ONES
       && !out_is_alu))
    else $error("unknown encoding without full barrier masks");

  // A recognized word never reports a write to the zero register.
  a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_unknown_opcode) |-> !out_write_mask[0])
    else $error("write to the zero register reported");

  // The rs/rt flags only accompany an ALU operation.
  a_alu_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alu_writes_rt || out_alu_reads_rs || out_alu_reads_rt)) |->
      out_is_alu)
    else $error("ALU operand flag set for a non-ALU word");

endmodule

bind mips_register_use_decoder_unit mrud_checker u_mrud_checker (.*);

/* tb/sv/tb_mips_register_use_decoder_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the MIPS I register use decoder: directed and random decode checks.
module tb_mips_register_use_decoder_unit;

  // Registers between a taken request and its taken result: input and result register.
  localparam int RESULT_LATENCY = 2;
  // Cycles with neither a request nor a result taken before the run is declared hung.
  // The slowest sender phase idles 84 percent of the time, so long gaps are normal;
  // this leaves a wide margin over them.
  localparam int WATCHDOG_LIMIT = 2000;

  // One predicted decode, tagged with the instruction word that produced it so that
  // mismatch reports can name it.
  typedef struct packed {
    logic [mrud_pkg::INSTR_W-1:0] instr;
    logic [mrud_pkg::MASK_W-1:0]  read_mask;
    logic [mrud_pkg::MASK_W-1:0]  write_mask;
    logic                         unknown_opcode;
    logic                         is_alu;
    logic                         alu_writes_rt;
    logic                         alu_reads_rs;
    logic                         alu_reads_rt;
  } reg_use_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [mrud_pkg::INSTR_W-1:0] in_instruction;
  logic                         out_valid;
  logic [mrud_pkg::MASK_W-1:0]  out_read_mask;
  logic [mrud_pkg::MASK_W-1:0]  out_write_mask;
  logic                         out_unknown_opcode;
  logic                         out_is_alu;
  logic                         out_alu_writes_rt;
  logic                         out_alu_reads_rs;
  logic                         out_alu_reads_rt;

  // Instruction words waiting to be sent, and decodes expected back, oldest first.
  logic [mrud_pkg::INSTR_W-1:0] instr_pending_q[$];
  reg_use_t                     reg_use_q[$];

  // Set at a rising edge when the request on the inputs was taken by the block.
  logic req_taken;
  // The driver holds off while this is set, until every expected decode has come back.
  logic drain_hold;
  int   send_idle_pct;
  int   mismatch_count;
  int   stall_cycles;

  // Every opcode the decoder recognizes, and every SPECIAL function code.
  logic [5:0] legal_ops [0:31] = '{
    mrud_pkg::OP_SPECIAL, mrud_pkg::OP_REGIMM, mrud_pkg::OP_J, mrud_pkg::OP_JAL,
    mrud_pkg::OP_BEQ, mrud_pkg::OP_BNE, mrud_pkg::OP_BLEZ, mrud_pkg::OP_BGTZ,
    mrud_pkg::OP_ADDI, mrud_pkg::OP_ADDIU, mrud_pkg::OP_SLTI, mrud_pkg::OP_SLTIU,
    mrud_pkg::OP_ANDI, mrud_pkg::OP_ORI, mrud_pkg::OP_XORI, mrud_pkg::OP_LUI,
    mrud_pkg::OP_COP0, mrud_pkg::OP_COP2, mrud_pkg::OP_LB, mrud_pkg::OP_LH,
    mrud_pkg::OP_LWL, mrud_pkg::OP_LW, mrud_pkg::OP_LBU, mrud_pkg::OP_LHU,
    mrud_pkg::OP_LWR, mrud_pkg::OP_SB, mrud_pkg::OP_SH, mrud_pkg::OP_SWL,
    mrud_pkg::OP_SW, mrud_pkg::OP_SWR, mrud_pkg::OP_LWC2, mrud_pkg::OP_SWC2
  };
  logic [5:0] legal_fns [0:27] = '{
    mrud_pkg::FN_SLL, mrud_pkg::FN_SRL, mrud_pkg::FN_SRA, mrud_pkg::FN_SLLV,
    mrud_pkg::FN_SRLV, mrud_pkg::FN_SRAV, mrud_pkg::FN_JR, mrud_pkg::FN_JALR,
    mrud_pkg::FN_SYSCALL, mrud_pkg::FN_BREAK, mrud_pkg::FN_MFHI, mrud_pkg::FN_MTHI,
    mrud_pkg::FN_MFLO, mrud_pkg::FN_MTLO, mrud_pkg::FN_MULT, mrud_pkg::FN_MULTU,
    mrud_pkg::FN_DIV, mrud_pkg::FN_DIVU, mrud_pkg::FN_ADD, mrud_pkg::FN_ADDU,
    mrud_pkg::FN_SUB, mrud_pkg::FN_SUBU, mrud_pkg::FN_AND, mrud_pkg::FN_OR,
    mrud_pkg::FN_XOR, mrud_pkg::FN_NOR, mrud_pkg::FN_SLT, mrud_pkg::FN_SLTU
  };

  mips_register_use_decoder_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_instruction     (in_instruction),
    .out_valid          (out_valid),
    .out_read_mask      (out_read_mask),
    .out_write_mask     (out_write_mask),
    .out_unknown_opcode (out_unknown_opcode),
    .out_is_alu         (out_is_alu),
    .out_alu_writes_rt  (out_alu_writes_rt),
    .out_alu_reads_rs   (out_alu_reads_rs),
    .out_alu_reads_rt   (out_alu_reads_rt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out which registers an instruction word reads and writes, plus the ALU
  // flags. A GPR write to the zero register is never reported, and an encoding that
  // is not recognized turns into a full barrier with both masks all ones.
  function automatic reg_use_t predict_reg_use(input logic [mrud_pkg::INSTR_W-1:0] w);
    logic [5:0]                  op;
    logic [5:0]                  fn;
    logic [4:0]                  rs;
    logic [4:0]                  rt;
    logic [mrud_pkg::MASK_W-1:0] rs_rd;
    logic [mrud_pkg::MASK_W-1:0] rt_rd;
    logic [mrud_pkg::MASK_W-1:0] both_rd;
    logic [mrud_pkg::MASK_W-1:0] rt_wr;
    logic [mrud_pkg::MASK_W-1:0] rd_wr;
    logic                        known;
    reg_use_t                    u;
    op = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    fn = w[5:0];
    rs_rd = '0;
    rs_rd[rs] = 1'b1;
    rt_rd = '0;
    rt_rd[rt] = 1'b1;
    both_rd = rs_rd | rt_rd;
    rt_wr = rt_rd;
    rt_wr[0] = 1'b0;
    rd_wr = '0;
    rd_wr[w[15:11]] = 1'b1;
    rd_wr[0] = 1'b0;
    u = '0;
    u.instr = w;
    known = 1'b1;

    case (op)
      mrud_pkg::OP_SPECIAL: begin
        case (fn)
          mrud_pkg::FN_SLL, mrud_pkg::FN_SRL, mrud_pkg::FN_SRA: begin
            u.read_mask = rt_rd;
            u.write_mask = rd_wr;
          end
          mrud_pkg::FN_SLLV, mrud_pkg::FN_SRLV, mrud_pkg::FN_SRAV, mrud_pkg::FN_ADD,
          mrud_pkg::FN_ADDU, mrud_pkg::FN_SUB, mrud_pkg::FN_SUBU, mrud_pkg::FN_AND,
          mrud_pkg::FN_OR, mrud_pkg::FN_XOR, mrud_pkg::FN_NOR, mrud_pkg::FN_SLT,
          mrud_pkg::FN_SLTU: begin
            u.read_mask = both_rd;
            u.write_mask = rd_wr;
          end
          mrud_pkg::FN_JR: u.read_mask = rs_rd;
          mrud_pkg::FN_JALR: begin
            u.read_mask = rs_rd;
            u.write_mask = rd_wr;
          end
          mrud_pkg::FN_SYSCALL, mrud_pkg::FN_BREAK: ;
          mrud_pkg::FN_MFHI: begin
            u.read_mask = mrud_pkg::HI_BIT;
            u.write_mask = rd_wr;
          end
          mrud_pkg::FN_MTHI: begin
            u.read_mask = rs_rd;
            u.write_mask = mrud_pkg::HI_BIT;
          end
          mrud_pkg::FN_MFLO: begin
            u.read_mask = mrud_pkg::LO_BIT;
            u.write_mask = rd_wr;
          end
          mrud_pkg::FN_MTLO: begin
            u.read_mask = rs_rd;
            u.write_mask = mrud_pkg::LO_BIT;
          end
          mrud_pkg::FN_MULT, mrud_pkg::FN_MULTU, mrud_pkg::FN_DIV,
          mrud_pkg::FN_DIVU: begin
            u.read_mask = both_rd;
            u.write_mask = mrud_pkg::LO_BIT | mrud_pkg::HI_BIT;
          end
          default: known = 1'b0;
        endcase
      end
      mrud_pkg::OP_REGIMM: begin
        if (rt == mrud_pkg::RT_BLTZ || rt == mrud_pkg::RT_BGEZ) begin
          u.read_mask = rs_rd;
        end else if (rt == mrud_pkg::RT_BLTZAL || rt == mrud_pkg::RT_BGEZAL) begin
          u.read_mask = rs_rd;
          u.write_mask[mrud_pkg::REG_RA] = 1'b1;
        end else begin
          known = 1'b0;
        end
      end
      mrud_pkg::OP_J: ;
      mrud_pkg::OP_JAL: u.write_mask[mrud_pkg::REG_RA] = 1'b1;
      mrud_pkg::OP_BEQ, mrud_pkg::OP_BNE: u.read_mask = both_rd;
      mrud_pkg::OP_BLEZ, mrud_pkg::OP_BGTZ: u.read_mask = rs_rd;
      mrud_pkg::OP_ADDI, mrud_pkg::OP_ADDIU, mrud_pkg::OP_SLTI, mrud_pkg::OP_SLTIU,
      mrud_pkg::OP_ANDI, mrud_pkg::OP_ORI, mrud_pkg::OP_XORI: begin
        u.read_mask = rs_rd;
        u.write_mask = rt_wr;
      end
      mrud_pkg::OP_LUI: u.write_mask = rt_wr;
      mrud_pkg::OP_COP0: begin
        // Any rs = CO word is taken as RFE, whatever the function bits say.
        if (rs == mrud_pkg::RS_MF) begin
          u.write_mask = rt_wr;
        end else if (rs == mrud_pkg::RS_MT) begin
          u.read_mask = rt_rd;
        end else if (rs != mrud_pkg::RS_CO) begin
          known = 1'b0;
        end
      end
      mrud_pkg::OP_COP2: begin
        // Every rs from 16 up is a GTE command that touches no GPR.
        if (rs == mrud_pkg::RS_MF || rs == mrud_pkg::RS_CF) begin
          u.write_mask = rt_wr;
        end else if (rs == mrud_pkg::RS_MT || rs == mrud_pkg::RS_CT) begin
          u.read_mask = rt_rd;
        end else if (!rs[4]) begin
          known = 1'b0;
        end
      end
      mrud_pkg::OP_LB, mrud_pkg::OP_LH, mrud_pkg::OP_LW, mrud_pkg::OP_LBU,
      mrud_pkg::OP_LHU: begin
        u.read_mask = rs_rd;
        u.write_mask = rt_wr;
      end
      mrud_pkg::OP_LWL, mrud_pkg::OP_LWR: begin
        u.read_mask = both_rd;
        u.write_mask = rt_wr;
      end
      mrud_pkg::OP_SB, mrud_pkg::OP_SH, mrud_pkg::OP_SWL, mrud_pkg::OP_SW,
      mrud_pkg::OP_SWR: u.read_mask = both_rd;
      mrud_pkg::OP_LWC2, mrud_pkg::OP_SWC2: u.read_mask = rs_rd;
      default: known = 1'b0;
    endcase

    if (!known) begin
      u.read_mask = mrud_pkg::ALL_ONES;
      u.write_mask = mrud_pkg::ALL_ONES;
      u.unknown_opcode = 1'b1;
    end

    // The ALU flags depend on the opcode and function code alone.
    if (op == mrud_pkg::OP_SPECIAL) begin
      case (fn)
        mrud_pkg::FN_SLL, mrud_pkg::FN_SRL, mrud_pkg::FN_SRA: begin
          u.is_alu = 1'b1;
          u.alu_reads_rt = 1'b1;
        end
        mrud_pkg::FN_SLLV, mrud_pkg::FN_SRLV, mrud_pkg::FN_SRAV, mrud_pkg::FN_ADD,
        mrud_pkg::FN_ADDU, mrud_pkg::FN_SUB, mrud_pkg::FN_SUBU, mrud_pkg::FN_AND,
        mrud_pkg::FN_OR, mrud_pkg::FN_XOR, mrud_pkg::FN_NOR, mrud_pkg::FN_SLT,
        mrud_pkg::FN_SLTU: begin
          u.is_alu = 1'b1;
          u.alu_reads_rs = 1'b1;
          u.alu_reads_rt = 1'b1;
        end
        default: ;
      endcase
    end else if (op >= mrud_pkg::OP_ADDI && op <= mrud_pkg::OP_LUI) begin
      u.is_alu = 1'b1;
      u.alu_writes_rt = 1'b1;
      u.alu_reads_rs = (op != mrud_pkg::OP_LUI);
    end
    return u;
  endfunction

  function automatic logic [mrud_pkg::INSTR_W-1:0] enc_r(
      input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] rd,
      input logic [4:0] sa, input logic [5:0] fn);
    return {mrud_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [mrud_pkg::INSTR_W-1:0] enc_i(
      input logic [5:0] op, input logic [4:0] rs, input logic [4:0] rt,
      input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Register fields lean toward the zero register and the link register, so that
  // suppressed writes and $ra hazards come up often.
  function automatic logic [4:0] pick_reg();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 5'd0;
    if (sel == 1) return 5'd31;
    return 5'($urandom);
  endfunction

  // Three quarters of the words are legal encodings with random register and
  // immediate content; the rest are near misses in the decoded families and raw noise.
  function automatic logic [mrud_pkg::INSTR_W-1:0] random_instr();
    logic [mrud_pkg::INSTR_W-1:0] w;
    int unsigned                  kind;
    w = $urandom;
    kind = $urandom_range(0, 99);
    if (kind >= 87) return w;
    if (kind >= 75) begin
      case ($urandom_range(0, 3))
        0: w[31:26] = mrud_pkg::OP_SPECIAL;
        1: w[31:26] = mrud_pkg::OP_REGIMM;
        2: w[31:26] = mrud_pkg::OP_COP0;
        default: w[31:26] = mrud_pkg::OP_COP2;
      endcase
      return w;
    end

    w[31:26] = (kind < 25) ? mrud_pkg::OP_SPECIAL : legal_ops[$urandom_range(0, 31)];
    w[25:21] = pick_reg();
    w[20:16] = pick_reg();
    w[15:11] = pick_reg();
    // Families whose rs, rt or funct field selects the operation get a legal code there.
    case (w[31:26])
      mrud_pkg::OP_SPECIAL: w[5:0] = legal_fns[$urandom_range(0, 27)];
      mrud_pkg::OP_REGIMM: w[19:17] = 3'b000;
      mrud_pkg::OP_COP0: begin
        case ($urandom_range(0, 2))
          0: w[25:21] = mrud_pkg::RS_MF;
          1: w[25:21] = mrud_pkg::RS_MT;
          default: w[25:21] = mrud_pkg::RS_CO;
        endcase
      end
      mrud_pkg::OP_COP2: begin
        if ($urandom_range(0, 1) == 1) begin
          w[25] = 1'b1;
        end else begin
          w[25:24] = 2'b00;
          w[21] = 1'b0;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic check_field(input string fname, input logic [mrud_pkg::INSTR_W-1:0] instr,
                             input logic [mrud_pkg::MASK_W-1:0] exp_v,
                             input logic [mrud_pkg::MASK_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch for instruction %h: expected %h, actual %h",
               $time, fname, instr, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Waits until every queued request has been taken and every decode has come back.
  // The sender has nothing to send meanwhile, so this is also a full pause.
  task automatic drain_all();
    do @(posedge clk); while (instr_pending_q.size() != 0 || start);
    while (reg_use_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int count);
    send_idle_pct = idle_pct;
    repeat (count) instr_pending_q.push_back(random_instr());
    drain_all();
  endtask

  // Driver: inputs change only at the falling edge. A raised request stays put until
  // the block takes it; otherwise the next word goes out unless the sender idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && req_taken !== 1'b1) begin
      // The block has not taken the current request yet, so it is held as it is.
    end else begin
      if (drain_hold && reg_use_q.size() == 0) drain_hold = 1'b0;
      if (!drain_hold && instr_pending_q.size() != 0 && $urandom_range(0, 99) == 0) begin
        drain_hold = 1'b1;
      end
      if (!drain_hold && instr_pending_q.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        start <= 1'b1;
        in_instruction <= instr_pending_q.pop_front();
      end else begin
        // The instruction bus carries junk while idle, which the block must ignore.
        start <= 1'b0;
        in_instruction <= $urandom;
      end
    end
  end

  // Monitor: samples at the rising edge. A taken request gets its decode predicted
  // right away; each result strobe is checked against the oldest prediction.
  always @(posedge clk) begin
    req_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) reg_use_q.push_back(predict_reg_use(in_instruction));

    if (rst_n && out_valid === 1'b1) begin
      if (reg_use_q.size() == 0) begin
        $display("%0t: result with no request pending: read mask %h, write mask %h",
                 $time, out_read_mask, out_write_mask);
        mismatch_count++;
      end else begin
        reg_use_t exp_use;
        exp_use = reg_use_q.pop_front();
        check_field("read_mask", exp_use.instr, exp_use.read_mask, out_read_mask);
        check_field("write_mask", exp_use.instr, exp_use.write_mask, out_write_mask);
        check_field("unknown_opcode", exp_use.instr,
                    mrud_pkg::MASK_W'(exp_use.unknown_opcode),
                    mrud_pkg::MASK_W'(out_unknown_opcode));
        check_field("is_alu", exp_use.instr, mrud_pkg::MASK_W'(exp_use.is_alu),
                    mrud_pkg::MASK_W'(out_is_alu));
        check_field("alu_writes_rt", exp_use.instr,
                    mrud_pkg::MASK_W'(exp_use.alu_writes_rt),
                    mrud_pkg::MASK_W'(out_alu_writes_rt));
        check_field("alu_reads_rs", exp_use.instr,
                    mrud_pkg::MASK_W'(exp_use.alu_reads_rs),
                    mrud_pkg::MASK_W'(out_alu_reads_rs));
        check_field("alu_reads_rt", exp_use.instr,
                    mrud_pkg::MASK_W'(exp_use.alu_reads_rt),
                    mrud_pkg::MASK_W'(out_alu_reads_rt));
      end
    end else if (rst_n && out_valid !== 1'b0) begin
      $display("%0t: out_valid is unknown: expected 0 or 1, actual %b", $time, out_valid);
      mismatch_count++;
    end

    // Watchdog: a stretch with nothing taken on either side means the run is hung.
    if ((rst_n && start && !busy) || out_valid === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, nothing taken for %0d cycles", $time, stall_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_instruction = '0;
    req_taken = 1'b0;
    drain_hold = 1'b0;
    send_idle_pct = 0;
    mismatch_count = 0;
    stall_cycles = 0;

    // Directed words: the all-zeros NOP and the all-ones word, writes aimed at the zero
    // register, the HI/LO moves, link writes to $ra, RFE with junk in its low bits, GTE
    // commands, near misses in each decoded family, and fields that must be ignored.
    instr_pending_q.push_back(32'h0000_0000);
    instr_pending_q.push_back(32'hffff_ffff);
    instr_pending_q.push_back(enc_r(5'd31, 5'd31, 5'd0, 5'd0, mrud_pkg::FN_ADDU));
    instr_pending_q.push_back(enc_r(5'd1, 5'd2, 5'd31, 5'd31, mrud_pkg::FN_SLT));
    instr_pending_q.push_back(enc_r(5'd31, 5'd0, 5'd31, 5'd31, mrud_pkg::FN_JALR));
    instr_pending_q.push_back(enc_r(5'd7, 5'd0, 5'd0, 5'd0, mrud_pkg::FN_JR));
    instr_pending_q.push_back(enc_r(5'd0, 5'd0, 5'd0, 5'd0, mrud_pkg::FN_MFHI));
    instr_pending_q.push_back(enc_r(5'd31, 5'd0, 5'd0, 5'd0, mrud_pkg::FN_MTLO));
    instr_pending_q.push_back(enc_r(5'd3, 5'd4, 5'd0, 5'd0, mrud_pkg::FN_DIVU));
    instr_pending_q.push_back({mrud_pkg::OP_SPECIAL, 20'hfffff, mrud_pkg::FN_BREAK});
    instr_pending_q.push_back(enc_r(5'd1, 5'd1, 5'd1, 5'd1, 6'h01));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_REGIMM, 5'd0, mrud_pkg::RT_BGEZAL,
                                    16'hffff));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_REGIMM, 5'd9, 5'h02, 16'h0000));
    instr_pending_q.push_back({mrud_pkg::OP_J, 26'h3ff_ffff});
    instr_pending_q.push_back({mrud_pkg::OP_JAL, 26'h000_0000});
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_LUI, 5'd31, 5'd0, 16'hffff));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_XORI, 5'd0, 5'd31, 16'h0000));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP0, mrud_pkg::RS_MF, 5'd12, 16'h0000));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP0, mrud_pkg::RS_MT, 5'd0, 16'h0000));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP0, mrud_pkg::RS_CO, 5'd31, 16'hffff));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP0, 5'h01, 5'd0, 16'h0000));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP2, 5'h1f, 5'd31, 16'hffff));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP2, mrud_pkg::RS_CF, 5'd31, 16'h0000));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_COP2, 5'h0f, 5'd0, 16'h0000));
    instr_pending_q.push_back(enc_i(mrud_pkg::OP_LWL, 5'd31, 5'd31, 16'h8000));
    instr_pending_q.push_back(enc_i(6'h11, 5'd0, 5'd0, 16'h0000));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    drain_all();

    // Random phases: back to back, a sparse sender, a lightly idling sender, and a
    // closing stretch back to back again.
    run_phase(0, 200);
    run_phase(84, 150);
    run_phase(16, 150);
    run_phase(0, 125);

    // Any stray result would show up within the pipeline depth.
    repeat (RESULT_LATENCY + 6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mrud_pkg.sv
hw/rtl/mrud_mask_dec.sv
hw/rtl/mrud_alu_class.sv
hw/rtl/mips_register_use_decoder_unit.sv
hw/rtl/mrud_checker.sv
tb/sv/tb_mips_register_use_decoder_unit.sv
